[sv/jtdbe_pkg.sv]
package jtdbe_pkg;

    localparam int IR_BITS = 4;
    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] ID_CODE_RESET = 32'h87654321;
    localparam logic [3:0] CONFREG_OPCODE_RESET = 4'd7;
    localparam logic [5:0] CONFREG_BITS_RESET = 6'd4;

    localparam logic [IR_BITS-1:0] OP_IDCODE = IR_BITS'(1);
    localparam logic [IR_BITS-1:0] OP_USER = IR_BITS'(4);
    localparam logic [IR_BITS-1:0] OP_BYPASS = {IR_BITS{1'b1}};

    // configuration register indexes
    localparam logic [1:0] REG_ID_CODE = 2'd0;
    localparam logic [1:0] REG_CONFREG_OPCODE = 2'd1;
    localparam logic [1:0] REG_CONFREG_BITS = 2'd2;

    // module 0 commands
    localparam logic [3:0] CMD_WR8 = 4'd1;
    localparam logic [3:0] CMD_WR16 = 4'd2;
    localparam logic [3:0] CMD_WR32 = 4'd3;
    localparam logic [3:0] CMD_RD8 = 4'd5;
    localparam logic [3:0] CMD_RD16 = 4'd6;
    localparam logic [3:0] CMD_RD32 = 4'd7;
    localparam logic [3:0] CMD_CLR_ERR = 4'd9;
    localparam logic [3:0] CMD_SEL_ERR = 4'd13;

    // burst phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CRC = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    typedef enum logic [3:0] {
        S_TLR, S_RTI, S_SELDR, S_CAPDR, S_SHDR, S_EX1DR, S_PAUSEDR, S_EX2DR,
        S_UPDDR, S_SELIR, S_CAPIR, S_SHIR, S_EX1IR, S_PAUSEIR, S_EX2IR, S_UPDIR
    } tap_state_t;

    typedef struct packed {
        logic [31:0] id_code;
        logic [3:0]  confreg_opcode;
        logic [5:0]  confreg_bits;
    } cfg_t;

    typedef struct packed {
        logic        tms;
        logic        tdi;
        logic [31:0] bus_read_data;
        logic        bus_error;
        logic [31:0] soc_status;
    } item_t;

    typedef struct packed {
        logic        tdo;
        logic        bus_request;
        logic        bus_write;
        logic [31:0] bus_address;
        logic [1:0]  bus_size;
        logic [31:0] bus_write_data;
        logic        confreg_strobe;
        logic [31:0] confreg_value;
    } result_t;

    // reflected CRC-32 over the low nbits of data, LSB first
    function automatic logic [31:0] crc_fold(input logic [31:0] crc_in,
                                             input logic [31:0] data,
                                             input logic [5:0] nbits);
        logic [31:0] c;
        logic fb;
        c = crc_in;
        for (int i = 0; i < 32; i++) begin
            if (6'(i) < nbits) begin
                fb = data[i] ^ c[0];
                c = c >> 1;
                if (fb)
                begin
                    c = c ^ CRC_POLY;
                end
            end
        end
        return c;
    endfunction

endpackage

[sv/jtdbe_tap.sv]
module jtdbe_tap (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  tms,
    output jtdbe_pkg::tap_state_t state
);
    import jtdbe_pkg::*;

    tap_state_t state_reg;
    tap_state_t state_next;

    // next TAP state
    always_comb
    begin
        case (state_reg)
            S_TLR:     state_next = tms ? S_TLR : S_RTI;
            S_RTI:     state_next = tms ? S_SELDR : S_RTI;
            S_SELDR:   state_next = tms ? S_SELIR : S_CAPDR;
            S_CAPDR:   state_next = tms ? S_EX1DR : S_SHDR;
            S_SHDR:    state_next = tms ? S_EX1DR : S_SHDR;
            S_EX1DR:   state_next = tms ? S_UPDDR : S_PAUSEDR;
            S_PAUSEDR: state_next = tms ? S_EX2DR : S_PAUSEDR;
            S_EX2DR:   state_next = tms ? S_UPDDR : S_SHDR;
            S_UPDDR:   state_next = tms ? S_SELDR : S_RTI;
            S_SELIR:   state_next = tms ? S_TLR : S_CAPIR;
            S_CAPIR:   state_next = tms ? S_EX1IR : S_SHIR;
            S_SHIR:    state_next = tms ? S_EX1IR : S_SHIR;
            S_EX1IR:   state_next = tms ? S_UPDIR : S_PAUSEIR;
            S_PAUSEIR: state_next = tms ? S_EX2IR : S_PAUSEIR;
            S_EX2IR:   state_next = tms ? S_UPDIR : S_SHIR;
            S_UPDIR:   state_next = tms ? S_SELDR : S_RTI;
            default:   state_next = S_TLR;
        endcase
    end

    // hold state unless an item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TLR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // expose current state
    always_comb
    begin
        state = state_reg;
    end

endmodule

[sv/jtdbe_core.sv]
module jtdbe_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  jtdbe_pkg::tap_state_t state,
    input  jtdbe_pkg::item_t      item,
    input  jtdbe_pkg::cfg_t       cfg,
    output jtdbe_pkg::result_t    result
);
    import jtdbe_pkg::*;

    logic [IR_BITS-1:0] instr_reg, instr_next;
    logic [IR_BITS-1:0] ir_shift_reg, ir_shift_next;
    logic [4:0]  module_sel_reg, module_sel_next;
    logic [63:0] cmd_shift_reg, cmd_shift_next;
    logic [31:0] gen_shift_reg, gen_shift_next;
    logic [31:0] id_shift_reg, id_shift_next;
    logic [31:0] cr_in_reg, cr_in_next;
    logic [31:0] cr_out_reg, cr_out_next;
    logic [2:0]  phase_reg, phase_next;
    logic        is_read_reg, is_read_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] words_reg, words_next;
    logic [5:0]  bits_reg, bits_next;
    logic [2:0]  bytes_reg, bytes_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] err_reg, err_next;

    logic        instr_is_cr;
    logic [5:0]  cr_len;
    logic [5:0]  nb;
    logic [31:0] rd_mask;
    logic [3:0]  op;
    logic [63:0] cmd;
    result_t     res;

    assign instr_is_cr = (8'(instr_reg) == 8'(cfg.confreg_opcode));
    assign nb = {bytes_reg, 3'b000};
    assign rd_mask = (nb >= 6'd32) ? 32'hffffffff : ((32'd1 << nb[4:0]) - 32'd1);

    // one TCK step of all data registers and the burst engine
    always_comb
    begin
        instr_next = instr_reg;
        ir_shift_next = ir_shift_reg;
        module_sel_next = module_sel_reg;
        cmd_shift_next = cmd_shift_reg;
        gen_shift_next = gen_shift_reg;
        id_shift_next = id_shift_reg;
        cr_in_next = cr_in_reg;
        cr_out_next = cr_out_reg;
        phase_next = phase_reg;
        is_read_next = is_read_reg;
        addr_next = addr_reg;
        words_next = words_reg;
        bits_next = bits_reg;
        bytes_next = bytes_reg;
        word_next = word_reg;
        crc_next = crc_reg;
        err_next = err_reg;
        res = '0;
        cmd = cmd_shift_reg;
        op = cmd_shift_reg[62:59];
        cr_len = cfg.confreg_bits;
        if (cr_len < 6'd1)
        begin
            cr_len = 6'd1;
        end
        if (cr_len > 6'd32)
        begin
            cr_len = 6'd32;
        end

        case (state)
            S_TLR:
            begin
                phase_next = PH_IDLE;
                err_next = '0;
                instr_next = OP_IDCODE;
            end
            S_CAPDR:
            begin
                if (module_sel_reg == 5'd0)
                begin
                    if (instr_is_cr)
                    begin
                        cr_out_next = item.soc_status;
                    end
                    else if (instr_reg == OP_IDCODE)
                    begin
                        id_shift_next = cfg.id_code;
                    end
                end
            end
            S_SHDR:
            begin
                if (instr_is_cr)
                begin
                    cr_in_next = cr_in_reg >> 1;
                    cr_in_next[5'(cr_len - 6'd1)] = cr_in_next[5'(cr_len - 6'd1)] | item.tdi;
                    res.tdo = cr_out_reg[0];
                    cr_out_next = cr_out_reg >> 1;
                end
                else if (instr_reg == OP_IDCODE)
                begin
                    res.tdo = id_shift_reg[0];
                    id_shift_next = {item.tdi, id_shift_reg[31:1]};
                end
                else if (instr_reg == OP_USER)
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        res.tdo = cmd_shift_reg[0];
                        cmd_shift_next = {item.tdi, cmd_shift_reg[63:1]};
                    end
                    else if (is_read_reg)
                    begin
                        // read burst: stream words then CRC
                        case (phase_reg)
                            PH_START:
                            begin
                                res.tdo = 1'b1;
                                phase_next = PH_DATA;
                                crc_next = 32'hffffffff;
                            end
                            PH_DATA:
                            begin
                                if (bits_reg == 6'd0)
                                begin
                                    if (module_sel_reg == 5'd0)
                                    begin
                                        res.bus_request = 1'b1;
                                        res.bus_address = addr_reg;
                                        res.bus_size = (bytes_reg == 3'd1) ? 2'd0 :
                                                       ((bytes_reg == 3'd2) ? 2'd1 : 2'd2);
                                        if (item.bus_error)
                                        begin
                                            err_next = {addr_reg[30:0], 1'b1};
                                            word_next = '0;
                                        end
                                        else
                                        begin
                                            word_next = item.bus_read_data & rd_mask;
                                        end
                                    end
                                    crc_next = crc_fold(crc_reg, word_next, nb);
                                    bits_next = nb;
                                end
                                res.tdo = word_next[0];
                                word_next = word_next >> 1;
                                bits_next = bits_next - 6'd1;
                                if (bits_next == 6'd0)
                                begin
                                    addr_next = addr_reg + 32'(bytes_reg);
                                    words_next = words_reg - 16'd1;
                                    if (words_next == 16'd0)
                                    begin
                                        phase_next = PH_CRC;
                                        bits_next = 6'd32;
                                        word_next = crc_next;
                                    end
                                end
                            end
                            PH_CRC:
                            begin
                                res.tdo = word_reg[0];
                                word_next = word_reg >> 1;
                                bits_next = bits_reg - 6'd1;
                                if (bits_next == 6'd0)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_DONE:
                            begin
                                phase_next = PH_IDLE;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    else
                    begin
                        // write burst: collect words, then CRC, then match bit
                        case (phase_reg)
                            PH_START:
                            begin
                                if (item.tdi)
                                begin
                                    phase_next = PH_DATA;
                                    crc_next = 32'hffffffff;
                                end
                            end
                            PH_DATA:
                            begin
                                if (bits_reg == 6'd0)
                                begin
                                    bits_next = nb;
                                end
                                word_next = word_reg >> 1;
                                if (nb > 6'd0 && nb <= 6'd32)
                                begin
                                    word_next[5'(nb - 6'd1)] = word_next[5'(nb - 6'd1)] | item.tdi;
                                end
                                bits_next = bits_next - 6'd1;
                                if (bits_next == 6'd0)
                                begin
                                    if (module_sel_reg == 5'd0)
                                    begin
                                        res.bus_request = 1'b1;
                                        res.bus_write = 1'b1;
                                        res.bus_address = addr_reg;
                                        res.bus_size = (bytes_reg == 3'd1) ? 2'd0 :
                                                       ((bytes_reg == 3'd2) ? 2'd1 : 2'd2);
                                        res.bus_write_data = word_next;
                                        if (item.bus_error)
                                        begin
                                            err_next = {addr_reg[30:0], 1'b1};
                                        end
                                    end
                                    crc_next = crc_fold(crc_reg, word_next, nb);
                                    addr_next = addr_reg + 32'(bytes_reg);
                                    words_next = words_reg - 16'd1;
                                    if (words_next == 16'd0)
                                    begin
                                        phase_next = PH_CRC;
                                        bits_next = 6'd32;
                                    end
                                end
                            end
                            PH_CRC:
                            begin
                                word_next = {item.tdi, word_reg[31:1]};
                                bits_next = bits_reg - 6'd1;
                                if (bits_next == 6'd0)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_DONE:
                            begin
                                res.tdo = (crc_reg == word_reg);
                                phase_next = PH_IDLE;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                else if (instr_reg == OP_BYPASS)
                begin
                    res.tdo = gen_shift_reg[0];
                    gen_shift_next = (gen_shift_reg >> 1) | 32'(item.tdi);
                end
                else
                begin
                    res.tdo = gen_shift_reg[0];
                    gen_shift_next = {item.tdi, gen_shift_reg[31:1]};
                end
            end
            S_UPDDR:
            begin
                if (instr_is_cr)
                begin
                    cr_out_next = item.soc_status;
                    res.confreg_strobe = 1'b1;
                    res.confreg_value = cr_in_reg;
                end
                else if (instr_reg == OP_USER)
                begin
                    cmd_shift_next = '0;
                    if (cmd[63])
                    begin
                        module_sel_next = cmd[62:58];
                    end
                    else if (module_sel_reg == 5'd1)
                    begin
                        if (op == CMD_WR32 || op == CMD_RD32)
                        begin
                            phase_next = PH_START;
                            is_read_next = (op == CMD_RD32);
                            bytes_next = 3'd4;
                            addr_next = cmd[54:23];
                            words_next = cmd[22:7];
                            bits_next = '0;
                        end
                        else if (op == CMD_CLR_ERR)
                        begin
                            err_next = '0;
                        end
                    end
                    else if (module_sel_reg == 5'd0)
                    begin
                        case (op)
                            CMD_WR8, CMD_WR16, CMD_WR32, CMD_RD8, CMD_RD16, CMD_RD32:
                            begin
                                phase_next = PH_START;
                                is_read_next = op[2];
                                bytes_next = (op[1:0] == 2'd1) ? 3'd1 :
                                             ((op[1:0] == 2'd2) ? 3'd2 : 3'd4);
                                word_next = '0;
                                addr_next = cmd[58:27];
                                words_next = cmd[26:11];
                                bits_next = '0;
                            end
                            CMD_CLR_ERR:
                            begin
                                err_next = '0;
                            end
                            CMD_SEL_ERR:
                            begin
                                cmd_shift_next = {32'd0, err_reg};
                            end
                            default:
                            begin
                                cmd_shift_next = '0;
                            end
                        endcase
                    end
                end
            end
            S_SHIR:
            begin
                res.tdo = ir_shift_reg[0];
                ir_shift_next = {item.tdi, ir_shift_reg[IR_BITS-1:1]};
            end
            S_UPDIR:
            begin
                instr_next = ir_shift_reg;
            end
            default:
            begin
                instr_next = instr_reg;
            end
        endcase
    end

    // advance state on each item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instr_reg <= OP_IDCODE;
            ir_shift_reg <= '0;
            module_sel_reg <= '0;
            cmd_shift_reg <= '0;
            gen_shift_reg <= '0;
            id_shift_reg <= '0;
            cr_in_reg <= '0;
            cr_out_reg <= '0;
            phase_reg <= PH_IDLE;
            is_read_reg <= 1'b0;
            addr_reg <= '0;
            words_reg <= '0;
            bits_reg <= '0;
            bytes_reg <= '0;
            word_reg <= '0;
            crc_reg <= 32'hffffffff;
            err_reg <= '0;
        end
        else if (advance)
        begin
            instr_reg <= instr_next;
            ir_shift_reg <= ir_shift_next;
            module_sel_reg <= module_sel_next;
            cmd_shift_reg <= cmd_shift_next;
            gen_shift_reg <= gen_shift_next;
            id_shift_reg <= id_shift_next;
            cr_in_reg <= cr_in_next;
            cr_out_reg <= cr_out_next;
            phase_reg <= phase_next;
            is_read_reg <= is_read_next;
            addr_reg <= addr_next;
            words_reg <= words_next;
            bits_reg <= bits_next;
            bytes_reg <= bytes_next;
            word_reg <= word_next;
            crc_reg <= crc_next;
            err_reg <= err_next;
        end
    end

    assign result = res;

endmodule

[sv/jtag_tap_debug_burst_engine.sv]
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | tms, tdi, bus_read_data, bus_error, soc_status
// out     | output    | out_valid/out_stall | tdo, bus_*, confreg_strobe, confreg_value
// cfg     | input     | cfg_write         | cfg_index, cfg_data
//
// One item per clock while out is not stalled; an accepted item passes through
// the input register, then the TAP/burst step into the result register.
// The CRC fold is a combinational XOR network, so throughput is one item a cycle unless out stalls.
// rst_n clears the TAP to Test-Logic-Reset and all chains and burst state.
// A stall on out holds the result register and backs up into in_stall.
module jtag_tap_debug_burst_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        tms,
    input  logic        tdi,
    input  logic [31:0] bus_read_data,
    input  logic        bus_error,
    input  logic [31:0] soc_status,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tdo,
    output logic        bus_request,
    output logic        bus_write,
    output logic [31:0] bus_address,
    output logic [1:0]  bus_size,
    output logic [31:0] bus_write_data,
    output logic        confreg_strobe,
    output logic [31:0] confreg_value,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import jtdbe_pkg::*;

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       item_valid_reg;
    result_t    res_reg;
    result_t    res_comb;
    logic       out_valid_reg;
    logic       fire;
    tap_state_t state;

    // step the item held in the input register when the result slot frees
    assign fire = item_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = item_valid_reg && !fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.id_code <= ID_CODE_RESET;
            cfg_reg.confreg_opcode <= CONFREG_OPCODE_RESET;
            cfg_reg.confreg_bits <= CONFREG_BITS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ID_CODE:        cfg_reg.id_code <= cfg_data;
                REG_CONFREG_OPCODE: cfg_reg.confreg_opcode <= cfg_data[3:0];
                REG_CONFREG_BITS:   cfg_reg.confreg_bits <= cfg_data[5:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= '{tms: tms, tdi: tdi, bus_read_data: bus_read_data,
                          bus_error: bus_error, soc_status: soc_status};
        end
    end

    jtdbe_tap u_tap (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .tms     (item_reg.tms),
        .state   (state)
    );

    jtdbe_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .state   (state),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (res_comb)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid = out_valid_reg;
    assign tdo = res_reg.tdo;
    assign bus_request = res_reg.bus_request;
    assign bus_write = res_reg.bus_write;
    assign bus_address = res_reg.bus_address;
    assign bus_size = res_reg.bus_size;
    assign bus_write_data = res_reg.bus_write_data;
    assign confreg_strobe = res_reg.confreg_strobe;
    assign confreg_value = res_reg.confreg_value;

    // a bus access and a confreg push never share one step
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.bus_request && res_reg.confreg_strobe))
        else $error("bus access and confreg strobe together");

    // idle bus write and address fields are zero
    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.bus_request) |-> (res_reg.bus_write == 1'b0 &&
        res_reg.bus_address == 32'd0))
        else $error("bus fields set without request");

    // backpressure only with a held result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without output stall");

    // a stepped item always lands in the result register
    a_land: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("result lost");

endmodule

[test/burst_engine_monitor.sv]
module burst_engine_monitor
    import jtdbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        tms,
    input  logic        tdi,
    input  logic [31:0] bus_read_data,
    input  logic        bus_error,
    input  logic [31:0] soc_status,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        tdo,
    input  logic        bus_request,
    input  logic        bus_write,
    input  logic [31:0] bus_address,
    input  logic [1:0]  bus_size,
    input  logic [31:0] bus_write_data,
    input  logic        confreg_strobe,
    input  logic [31:0] confreg_value,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    // configuration copy
    logic [31:0] id_word;
    logic [3:0]  chain_opcode;
    logic [5:0]  chain_len;

    // TAP and burst state
    tap_state_t         tap;
    logic [IR_BITS-1:0] ir, ir_sh;
    logic [4:0]         module_sel;
    logic [63:0]        cmd_sh;
    logic [31:0]        gen_sh, id_sh, chain_in, chain_out;
    logic [2:0]         phase;
    logic               reading;
    logic [31:0]        addr;
    logic [15:0]        words_left;
    logic [5:0]         bits_left;
    logic [2:0]         beat_bytes;
    logic [31:0]        word, crc, err_word;

    result_t expected_results[$];

    function automatic logic [31:0] crc_shift_in(logic [31:0] c, logic [31:0] d, int n);
        logic fb;
        for (int i = 0; i < n && i < 32; i++)
        begin
            fb = d[i] ^ c[0];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_state();
        id_word = ID_CODE_RESET;
        chain_opcode = CONFREG_OPCODE_RESET;
        chain_len = CONFREG_BITS_RESET;
        tap = S_TLR;
        ir = OP_IDCODE;
        ir_sh = '0;
        module_sel = '0;
        cmd_sh = '0;
        gen_sh = '0;
        id_sh = '0;
        chain_in = '0;
        chain_out = '0;
        phase = PH_IDLE;
        reading = 1'b0;
        addr = '0;
        words_left = '0;
        bits_left = '0;
        beat_bytes = '0;
        word = '0;
        crc = '1;
        err_word = '0;
    endtask

    task automatic open_burst(input logic [2:0] bytes, input logic rd, input logic [63:0] f);
        phase = PH_START;
        reading = rd;
        beat_bytes = bytes;
        word = '0;
        addr = f[47:16];
        words_left = f[15:0];
        bits_left = '0;
    endtask

    task automatic run_command(input logic [63:0] cmd);
        logic [3:0]  op;
        logic [31:0] keep;
        op = cmd[62:59];
        if (module_sel == 5'd1)
        begin
            if (op == CMD_WR32 || op == CMD_RD32)
            begin
                keep = word;
                open_burst(3'd4, op == CMD_RD32, cmd >> 7);
                word = keep;
            end
            else if (op == CMD_CLR_ERR)
            begin
                err_word = '0;
            end
        end
        else if (module_sel == 5'd0)
        begin
            case (op)
                CMD_WR8:     open_burst(3'd1, 1'b0, cmd >> 11);
                CMD_WR16:    open_burst(3'd2, 1'b0, cmd >> 11);
                CMD_WR32:    open_burst(3'd4, 1'b0, cmd >> 11);
                CMD_RD8:     open_burst(3'd1, 1'b1, cmd >> 11);
                CMD_RD16:    open_burst(3'd2, 1'b1, cmd >> 11);
                CMD_RD32:    open_burst(3'd4, 1'b1, cmd >> 11);
                CMD_CLR_ERR: err_word = '0;
                CMD_SEL_ERR: cmd_sh = {32'd0, err_word};
                default: ;
            endcase
        end
    endtask

    task automatic bus_access(input logic wr, input logic [31:0] d, inout result_t r);
        r.bus_request = 1'b1;
        r.bus_write = wr;
        r.bus_address = addr;
        r.bus_size = (beat_bytes == 3'd1) ? 2'd0 : ((beat_bytes == 3'd2) ? 2'd1 : 2'd2);
        r.bus_write_data = wr ? d : 32'd0;
    endtask

    // one burst bit while USER is selected and a burst is open
    task automatic burst_bit(input logic di, input logic [31:0] rdata, input logic berr,
                             inout result_t r);
        int          nb;
        logic [31:0] m;
        nb = int'(beat_bytes) * 8;
        if (reading)
        begin
            case (phase)
                PH_START:
                begin
                    r.tdo = 1'b1;
                    phase = PH_DATA;
                    crc = '1;
                end
                PH_DATA:
                begin
                    if (bits_left == 0)
                    begin
                        if (module_sel == 5'd0)
                        begin
                            m = (nb >= 32) ? '1 : ((32'd1 << nb) - 32'd1);
                            bus_access(1'b0, 32'd0, r);
                            if (berr)
                            begin
                                err_word = {addr[30:0], 1'b1};
                                word = '0;
                            end
                            else
                            begin
                                word = rdata & m;
                            end
                        end
                        crc = crc_shift_in(crc, word, nb);
                        bits_left = 6'(nb);
                    end
                    r.tdo = word[0];
                    word = word >> 1;
                    bits_left = bits_left - 6'd1;
                    if (bits_left == 0)
                    begin
                        addr = addr + 32'(beat_bytes);
                        words_left = words_left - 16'd1;
                        if (words_left == 0)
                        begin
                            phase = PH_CRC;
                            bits_left = 6'd32;
                            word = crc;
                        end
                    end
                end
                PH_CRC:
                begin
                    r.tdo = word[0];
                    word = word >> 1;
                    bits_left = bits_left - 6'd1;
                    if (bits_left == 0)
                    begin
                        phase = PH_DONE;
                    end
                end
                PH_DONE: phase = PH_IDLE;
                default: ;
            endcase
        end
        else
        begin
            case (phase)
                PH_START:
                begin
                    if (di)
                    begin
                        phase = PH_DATA;
                        crc = '1;
                    end
                end
                PH_DATA:
                begin
                    if (bits_left == 0)
                    begin
                        bits_left = 6'(nb);
                    end
                    word = word >> 1;
                    if (nb > 0)
                    begin
                        word[nb-1] = word[nb-1] | di;
                    end
                    bits_left = bits_left - 6'd1;
                    if (bits_left == 0)
                    begin
                        if (module_sel == 5'd0)
                        begin
                            bus_access(1'b1, word, r);
                            if (berr)
                            begin
                                err_word = {addr[30:0], 1'b1};
                            end
                        end
                        crc = crc_shift_in(crc, word, nb);
                        addr = addr + 32'(beat_bytes);
                        words_left = words_left - 16'd1;
                        if (words_left == 0)
                        begin
                            phase = PH_CRC;
                            bits_left = 6'd32;
                        end
                    end
                end
                PH_CRC:
                begin
                    word = {di, word[31:1]};
                    bits_left = bits_left - 6'd1;
                    if (bits_left == 0)
                    begin
                        phase = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    r.tdo = (crc == word);
                    phase = PH_IDLE;
                end
                default: ;
            endcase
        end
    endtask

    task automatic shift_dr(input logic di, input logic [31:0] rdata, input logic berr,
                            inout result_t r);
        int len;
        if (ir == chain_opcode)
        begin
            len = (chain_len < 1) ? 1 : ((chain_len > 32) ? 32 : int'(chain_len));
            chain_in = (chain_in >> 1) | (32'(di) << (len - 1));
            r.tdo = chain_out[0];
            chain_out = chain_out >> 1;
        end
        else if (ir == OP_IDCODE)
        begin
            r.tdo = id_sh[0];
            id_sh = {di, id_sh[31:1]};
        end
        else if (ir == OP_USER)
        begin
            if (phase != PH_IDLE)
            begin
                burst_bit(di, rdata, berr, r);
            end
            else
            begin
                r.tdo = cmd_sh[0];
                cmd_sh = {di, cmd_sh[63:1]};
            end
        end
        else if (ir == OP_BYPASS)
        begin
            r.tdo = gen_sh[0];
            gen_sh = (gen_sh >> 1) | 32'(di);
        end
        else
        begin
            r.tdo = gen_sh[0];
            gen_sh = {di, gen_sh[31:1]};
        end
    endtask

    task automatic update_data(input logic [31:0] status, inout result_t r);
        logic [63:0] cmd;
        if (ir == chain_opcode)
        begin
            chain_out = status;
            r.confreg_strobe = 1'b1;
            r.confreg_value = chain_in;
        end
        else if (ir == OP_USER)
        begin
            cmd = cmd_sh;
            cmd_sh = '0;
            if (cmd[63])
            begin
                module_sel = cmd[62:58];
            end
            else
            begin
                run_command(cmd);
            end
        end
    endtask

    // advance the TAP by one TCK step and form the result it gives
    task automatic step_tap(input logic ms, input logic di, input logic [31:0] rdata,
                            input logic berr, input logic [31:0] status, output result_t r);
        r = '0;
        case (tap)
            S_TLR:
            begin
                phase = PH_IDLE;
                err_word = '0;
                ir = OP_IDCODE;
                tap = ms ? S_TLR : S_RTI;
            end
            S_RTI:   tap = ms ? S_SELDR : S_RTI;
            S_SELDR: tap = ms ? S_SELIR : S_CAPDR;
            S_CAPDR:
            begin
                if (module_sel == 5'd0)
                begin
                    if (ir == chain_opcode)
                    begin
                        chain_out = status;
                    end
                    else if (ir == OP_IDCODE)
                    begin
                        id_sh = id_word;
                    end
                end
                tap = ms ? S_EX1DR : S_SHDR;
            end
            S_SHDR:
            begin
                shift_dr(di, rdata, berr, r);
                if (ms)
                begin
                    tap = S_EX1DR;
                end
            end
            S_EX1DR:   tap = ms ? S_UPDDR : S_PAUSEDR;
            S_PAUSEDR: tap = ms ? S_EX2DR : S_PAUSEDR;
            S_EX2DR:   tap = ms ? S_UPDDR : S_SHDR;
            S_UPDDR:
            begin
                update_data(status, r);
                tap = ms ? S_SELDR : S_RTI;
            end
            S_SELIR: tap = ms ? S_TLR : S_CAPIR;
            S_CAPIR: tap = ms ? S_EX1IR : S_SHIR;
            S_SHIR:
            begin
                r.tdo = ir_sh[0];
                ir_sh = {di, ir_sh[IR_BITS-1:1]};
                if (ms)
                begin
                    tap = S_EX1IR;
                end
            end
            S_EX1IR:   tap = ms ? S_UPDIR : S_PAUSEIR;
            S_PAUSEIR: tap = ms ? S_EX2IR : S_PAUSEIR;
            S_EX2IR:   tap = ms ? S_UPDIR : S_SHIR;
            default:
            begin
                ir = ir_sh;
                tap = ms ? S_SELDR : S_RTI;
            end
        endcase
    endtask

    // watch config, inputs and results at each edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            clear_state();
            expected_results.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ID_CODE:        id_word = cfg_data;
                    REG_CONFREG_OPCODE: chain_opcode = cfg_data[3:0];
                    REG_CONFREG_BITS:   chain_len = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = '{tdo, bus_request, bus_write, bus_address, bus_size,
                        bus_write_data, confreg_strobe, confreg_value};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result item: %p", got);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.tdo !== want.tdo || got.bus_request !== want.bus_request ||
                        got.bus_write !== want.bus_write ||
                        got.bus_address !== want.bus_address ||
                        got.bus_size !== want.bus_size ||
                        got.bus_write_data !== want.bus_write_data ||
                        got.confreg_strobe !== want.confreg_strobe ||
                        got.confreg_value !== want.confreg_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", got);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                step_tap(tms, tdi, bus_read_data, bus_error, soc_status, want);
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

[test/tb.sv]
module tb;
    import jtdbe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        tms;
    logic        tdi;
    logic [31:0] bus_read_data;
    logic        bus_error;
    logic [31:0] soc_status;
    logic        out_valid;
    logic        out_stall;
    logic        tdo;
    logic        bus_request;
    logic        bus_write;
    logic [31:0] bus_address;
    logic [1:0]  bus_size;
    logic [31:0] bus_write_data;
    logic        confreg_strobe;
    logic [31:0] confreg_value;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          mismatches;
    int          pending;

    int          sent;
    bit          calm;
    bit          hold_req;
    logic [3:0]  chain_op;

    jtag_tap_debug_burst_engine dut (.*);
    burst_engine_monitor monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stall per item, plus one long hold-off on request
    initial
    begin
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            w = calm ? 0 : $urandom_range(0, 11);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(negedge clk);
            while (!out_valid) @(negedge clk);
            @(posedge clk);
        end
    end

    function automatic logic [31:0] fold_crc(logic [31:0] c, logic [31:0] d, int n);
        logic fb;
        for (int i = 0; i < n; i++)
        begin
            fb = d[i] ^ c[0];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // offer one TCK item and hold it until accepted
    task automatic put(input logic ms, input logic di);
        int w;
        w = calm ? 0 : $urandom_range(0, 11);
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1'b1;
        tms <= ms;
        tdi <= di;
        bus_read_data <= $urandom;
        bus_error <= ($urandom_range(0, 7) == 0);
        soc_status <= $urandom;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic new_config(input logic [31:0] id, input logic [3:0] op,
                              input logic [5:0] len);
        drain();
        set_reg(REG_ID_CODE, id);
        set_reg(REG_CONFREG_OPCODE, 32'(op));
        set_reg(REG_CONFREG_BITS, 32'(len));
        cfg_write <= 1'b0;
        chain_op = op;
    endtask

    // walk to Test-Logic-Reset, clear there, land in Run-Test/Idle
    task automatic go_reset();
        repeat (6) put(1'b1, $urandom);
        put(1'b0, $urandom);
    endtask

    task automatic load_ir(input logic [IR_BITS-1:0] op);
        put(1'b1, $urandom);
        put(1'b1, $urandom);
        put(1'b0, $urandom);
        put(1'b0, $urandom);
        for (int i = 0; i < IR_BITS; i++)
        begin
            put(i == IR_BITS - 1, op[i]);
        end
        put(1'b1, $urandom);
        put(1'b0, $urandom);
    endtask

    task automatic enter_dr();
        put(1'b1, $urandom);
        put(1'b0, $urandom);
        put(1'b0, $urandom);
    endtask

    // shift one DR bit; last bit runs update and returns to idle
    task automatic dr_bit(input logic di, input bit last);
        if (last)
        begin
            put(1'b1, di);
            put(1'b1, $urandom);
            put(1'b0, $urandom);
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            put(1'b1, di);
            put(1'b0, $urandom);
            repeat ($urandom_range(0, 3)) put(1'b0, $urandom);
            put(1'b1, $urandom);
            put(1'b0, $urandom);
        end
        else
        begin
            put(1'b0, di);
        end
    endtask

    task automatic scan_dr(input logic [63:0] v, input int n);
        enter_dr();
        for (int i = 0; i < n; i++)
        begin
            dr_bit(v[i], i == n - 1);
        end
    endtask

    task automatic user_cmd(input logic [63:0] cmd);
        load_ir(OP_USER);
        scan_dr(cmd, 64);
    endtask

    task automatic pick_module(input logic [4:0] m);
        user_cmd({1'b1, m, 26'($urandom), 32'($urandom)});
    endtask

    function automatic logic [63:0] burst_command(int m, logic [3:0] op, logic [31:0] a,
                                                  logic [15:0] n);
        if (m == 1)
        begin
            return {1'b0, op, 4'($urandom), a, n, 7'($urandom)};
        end
        return {1'b0, op, a, n, 11'($urandom)};
    endfunction

    // write burst with a correct or broken CRC trailer
    task automatic write_burst(input int m, input logic [3:0] op, input int bytes,
                               input int n);
        logic [31:0] c;
        logic [31:0] wd;
        int          nb;
        nb = bytes * 8;
        user_cmd(burst_command(m, op, $urandom, 16'(n)));
        enter_dr();
        repeat ($urandom_range(0, 3)) dr_bit(1'b0, 0);
        dr_bit(1'b1, 0);
        c = '1;
        for (int k = 0; k < n; k++)
        begin
            wd = $urandom;
            for (int i = 0; i < nb; i++)
            begin
                dr_bit(wd[i], 0);
            end
            c = fold_crc(c, wd, nb);
        end
        if ($urandom_range(0, 5) == 0)
        begin
            c[$urandom_range(0, 31)] ^= 1'b1;
        end
        for (int i = 0; i < 32; i++)
        begin
            dr_bit(c[i], 0);
        end
        dr_bit($urandom, 1);
    endtask

    task automatic read_burst(input int m, input logic [3:0] op, input int bytes,
                              input int n);
        int steps;
        steps = n * bytes * 8 + 34;
        user_cmd(burst_command(m, op, $urandom, 16'(n)));
        enter_dr();
        for (int i = 0; i < steps; i++)
        begin
            dr_bit($urandom, i == steps - 1);
        end
    endtask

    task automatic random_module0_burst();
        int sz;
        sz = $urandom_range(0, 2);
        if ($urandom_range(0, 1))
        begin
            read_burst(0, sz == 0 ? CMD_RD8 : (sz == 1 ? CMD_RD16 : CMD_RD32),
                       1 << sz, $urandom_range(1, 4));
        end
        else
        begin
            write_burst(0, sz == 0 ? CMD_WR8 : (sz == 1 ? CMD_WR16 : CMD_WR32),
                        1 << sz, $urandom_range(1, 4));
        end
    endtask

    task automatic random_config();
        logic [31:0] id;
        logic [3:0]  op;
        logic [5:0]  len;
        case ($urandom_range(0, 2))
            0:       id = 32'd0;
            1:       id = '1;
            default: id = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       op = 4'd0;
            1:       op = 4'hf;
            2:       op = CONFREG_OPCODE_RESET;
            default: op = 4'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       len = 6'd0;
            1:       len = 6'd1;
            2:       len = 6'd32;
            3:       len = 6'd63;
            default: len = 6'($urandom);
        endcase
        new_config(id, op, len);
    endtask

    initial
    begin
        int pick;
        int next_cfg;
        bit held;
        rst_n = 1'b0;
        in_valid = 1'b0;
        tms = 1'b1;
        tdi = 1'b0;
        bus_read_data = '0;
        bus_error = 1'b0;
        soc_status = '0;
        cfg_write = 1'b0;
        cfg_index = REG_ID_CODE;
        cfg_data = '0;
        sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        held = 1'b0;
        chain_op = CONFREG_OPCODE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each chain, a write and a read burst, module 1 and error select
        new_config(32'h0, 4'd7, 6'd32);
        go_reset();
        scan_dr({$urandom, $urandom}, 32);
        load_ir(OP_BYPASS);
        scan_dr({$urandom, $urandom}, 40);
        load_ir(chain_op);
        scan_dr({$urandom, $urandom}, 32);
        write_burst(0, CMD_WR8, 1, 2);
        read_burst(0, CMD_RD16, 2, 1);
        user_cmd({1'b0, CMD_SEL_ERR, 59'($urandom)});
        scan_dr({$urandom, $urandom}, 64);
        pick_module(5'd1);
        write_burst(1, CMD_WR32, 4, 1);
        pick_module(5'd0);
        new_config('1, 4'hf, 6'd0);
        load_ir(4'hf);
        scan_dr({$urandom, $urandom}, 20);
        // zero count wraps: shift a while, then abort through reset
        user_cmd(burst_command(0, CMD_RD8, $urandom, 16'd0));
        enter_dr();
        repeat (40) put(1'b0, $urandom);
        go_reset();
        new_config(ID_CODE_RESET, 4'd1, 6'd1);
        scan_dr({$urandom, $urandom}, 8);
        new_config($urandom, CONFREG_OPCODE_RESET, CONFREG_BITS_RESET);

        // random transactions, config changed every few hundred items
        next_cfg = sent + 300;
        while (sent < 1450)
        begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (!held)
            begin
                held = 1'b1;
                hold_req = 1'b1;
                read_burst(0, CMD_RD32, 4, 4);
                drain();
            end
            else if (pick < 45)
            begin
                random_module0_burst();
            end
            else if (pick < 52)
            begin
                pick_module(5'd1);
                if ($urandom_range(0, 1))
                begin
                    read_burst(1, CMD_RD32, 4, $urandom_range(1, 2));
                end
                else
                begin
                    write_burst(1, CMD_WR32, 4, $urandom_range(1, 2));
                end
                pick_module(5'd0);
            end
            else if (pick < 60)
            begin
                user_cmd({1'b0, CMD_SEL_ERR, 59'($urandom)});
                scan_dr({$urandom, $urandom}, 64);
                if ($urandom_range(0, 1))
                begin
                    user_cmd({1'b0, CMD_CLR_ERR, 59'($urandom)});
                end
            end
            else if (pick < 70)
            begin
                load_ir(IR_BITS'($urandom));
                scan_dr({$urandom, $urandom}, $urandom_range(1, 40));
            end
            else if (pick < 78)
            begin
                load_ir(chain_op);
                scan_dr({$urandom, $urandom}, $urandom_range(1, 40));
            end
            else if (pick < 85)
            begin
                user_cmd({1'b0, 63'({$urandom, $urandom})});
                pick_module(5'd0);
            end
            else
            begin
                // noise, then recover through reset
                repeat ($urandom_range(5, 30)) put($urandom, $urandom);
                go_reset();
            end
            if (sent >= next_cfg)
            begin
                random_config();
                next_cfg = sent + 300;
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[jtag_tap_debug_burst_engine.f]
sv/jtdbe_pkg.sv
sv/jtdbe_tap.sv
sv/jtdbe_core.sv
sv/jtag_tap_debug_burst_engine.sv
test/burst_engine_monitor.sv
test/tb.sv
